[rtl/core/rpn_stack_calculator_defines.svh]
// Assertion macros for the RPN stack calculator.
`ifndef RPN_STACK_CALCULATOR_DEFINES_SVH
`define RPN_STACK_CALCULATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define RPN_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define RPN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define RPN_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define RPN_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/core/rpn_pkg.sv]
// Package with operation and status codes for the RPN stack calculator.
package rpn_pkg;
  localparam int unsigned OP_W = 3;
  localparam int unsigned ST_W = 3;
  localparam logic [OP_W-1:0] OP_PUSH = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD = 3'd1;
  localparam logic [OP_W-1:0] OP_SUB = 3'd2;
  localparam logic [OP_W-1:0] OP_MUL = 3'd3;
  localparam logic [OP_W-1:0] OP_DIV = 3'd4;
  localparam logic [ST_W-1:0] ST_OK = 3'd0;
  localparam logic [ST_W-1:0] ST_FEW = 3'd1;
  localparam logic [ST_W-1:0] ST_FULL = 3'd2;
  localparam logic [ST_W-1:0] ST_DIV0 = 3'd3;
  localparam logic [ST_W-1:0] ST_SAT = 3'd4;
  localparam logic [63:0] MAX_POS = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MIN_NEG = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic       start;
    logic       is_div;
    logic [63:0] a;
    logic [63:0] b;
  } rpn_alu_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] res;
    logic [ST_W-1:0] st;
  } rpn_alu_rsp_t;

  function automatic logic [63:0] rpn_sat(input logic [127:0] mag, input logic neg,
                                          output logic sat);
    sat = 1'b0;
    if (neg) begin
      if (mag > {64'd0, MIN_NEG}) begin
        sat = 1'b1;
        return MIN_NEG;
      end
      return 64'd0 - mag[63:0];
    end
    if (mag > {64'd0, MAX_POS}) begin
      sat = 1'b1;
      return MAX_POS;
    end
    return mag[63:0];
  endfunction
endpackage

[rtl/core/rpn_muldiv.sv]
// Iterative multiply (four 32x32 partial products) and restoring divider.
module rpn_muldiv
  import rpn_pkg::*;
#(
  parameter int unsigned FRACTION_BITS = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  rpn_alu_req_t req,
  output rpn_alu_rsp_t rsp
);
  typedef enum logic [2:0] {S_IDLE, S_MUL, S_DIV, S_FIN} state_t;
  state_t state_r;
  logic [7:0] cnt_r;
  logic [63:0] ma_r, mb_r;
  logic neg_r, div_r;
  logic [127:0] acc_r;
  logic [127:0] num_r;
  logic [64:0] rem_r;
  logic [63:0] prod_r;
  logic [63:0] res_r;
  logic [ST_W-1:0] st_r;
  logic done_r;
  logic [64:0] rsh;
  logic [127:0] fin_mag;
  logic sat;
  logic [63:0] sres;
  logic [1:0] pcnt;
  logic [6:0] pshift;

  always_comb begin
    rsh = {rem_r[63:0], num_r[127]};
    fin_mag = div_r ? acc_r : (acc_r >> FRACTION_BITS);
    sres = rpn_sat(fin_mag, neg_r, sat);
    pcnt = cnt_r[1:0] - 2'd1;
    pshift = {pcnt[1] & pcnt[0], pcnt[1] ^ pcnt[0], 5'd0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= ((state_r == S_IDLE) && req.start && req.is_div && (req.b == 64'd0)) ||
                (state_r == S_FIN);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (req.start) begin
            ma_r <= req.a[63] ? 64'd0 - req.a : req.a;
            mb_r <= req.b[63] ? 64'd0 - req.b : req.b;
            neg_r <= req.a[63] ^ req.b[63];
            div_r <= req.is_div;
            acc_r <= '0;
            rem_r <= '0;
            cnt_r <= '0;
            num_r <= '0;
            if (req.is_div && req.b == 64'd0) begin
              res_r <= (req.a == 64'd0) ? 64'd0 : (req.a[63] ? MIN_NEG : MAX_POS);
              st_r <= ST_DIV0;
              state_r <= S_IDLE;
            end else begin
              state_r <= req.is_div ? S_DIV : S_MUL;
            end
          end
        end
        S_MUL: begin
          prod_r <= {32'd0, (cnt_r[0] ? ma_r[63:32] : ma_r[31:0])} *
                    {32'd0, (cnt_r[1] ? mb_r[63:32] : mb_r[31:0])};
          if (cnt_r != 8'd0) begin
            acc_r <= acc_r + ({64'd0, prod_r} << pshift);
          end
          cnt_r <= cnt_r + 8'd1;
          if (cnt_r == 8'd4) state_r <= S_FIN;
        end
        S_DIV: begin
          if (cnt_r == 8'd0) begin
            num_r <= {64'd0, ma_r} << FRACTION_BITS;
            cnt_r <= 8'd1;
          end else begin
            num_r <= num_r << 1;
            if (rsh >= {1'b0, mb_r}) begin
              rem_r <= rsh - {1'b0, mb_r};
              acc_r <= {acc_r[126:0], 1'b1};
            end else begin
              rem_r <= rsh;
              acc_r <= {acc_r[126:0], 1'b0};
            end
            cnt_r <= cnt_r + 8'd1;
            if (cnt_r == 8'd128) state_r <= S_FIN;
          end
        end
        S_FIN: begin
          res_r <= sres;
          st_r <= sat ? ST_SAT : ST_OK;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign rsp.done = done_r;
  assign rsp.res = res_r;
  assign rsp.st = st_r;
endmodule

[rtl/core/rpn_stack_calculator.sv]
// Top level of the RPN stack calculator: operand memory, sequencer and result register.
//  channel | ports                 | fields from the lowest bit
//  input   | in_tdata, in_tuser    | tdata: number[63:0]; tuser: op[2:0]
//  result  | out_tdata, out_tuser  | tdata: top_value[63:0], depth[68:64], zero pad;
//          |                       | tuser: status[2:0]
// Transactions are taken one at a time: the next is accepted only once the result of the last is registered.
// A divide by a nonzero divisor runs 128 one-bit divider steps.
// The result becomes valid in the same cycle as the next transaction can be taken.
// Reset is synchronous; the operand memory is not cleared and only entries below the depth are used.
// A stalled result register holds the next item in its final state until the register empties.
`include "rpn_stack_calculator_defines.svh"
module rpn_stack_calculator
  import rpn_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 16,
  parameter int unsigned FRACTION_BITS = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [63:0]     in_tdata,   // number
  input  logic [OP_W-1:0] in_tuser,   // op
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [71:0]     out_tdata,  // top_value, depth, zero pad
  output logic [ST_W-1:0] out_tuser   // status
);
  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [2:0] {S_IDLE, S_RD2, S_RD1, S_EXEC, S_WAIT, S_TOP, S_OUT} state_t;
  state_t state_r;
  logic [63:0] mem [STACK_DEPTH];
  logic [63:0] rdata_r, first_r, second_r, res_r;
  logic [AW-1:0] raddr;
  logic [CW-1:0] cnt_r;
  logic [OP_W-1:0] op_r;
  logic [ST_W-1:0] st_r;
  logic [71:0] out_r;
  logic ovalid_r;
  logic we;
  logic [AW-1:0] waddr;
  logic [63:0] wdata;
  rpn_alu_req_t req;
  rpn_alu_rsp_t rsp;
  logic [63:0] sum, dif;

  rpn_muldiv #(.FRACTION_BITS(FRACTION_BITS)) u_md (.clk(clk), .rst_n(rst_n), .req(req),
                                                  .rsp(rsp));

  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = ovalid_r;
  assign out_tdata = {3'd0, out_r[68:0]};
  assign out_tuser = out_r[71:69];
  assign sum = first_r + second_r;
  assign dif = first_r - second_r;

  always_comb begin
    raddr = '0;
    case (state_r)
      S_IDLE: raddr = cnt_r[AW-1:0] - AW'(1);
      S_RD2: raddr = cnt_r[AW-1:0] - AW'(2);
      S_TOP: raddr = cnt_r[AW-1:0] - AW'(1);
      default: raddr = cnt_r[AW-1:0] - AW'(1);
    endcase
    req.start = (state_r == S_EXEC) && (op_r == OP_MUL || op_r == OP_DIV);
    req.is_div = (op_r == OP_DIV);
    req.a = first_r;
    req.b = second_r;
    we = 1'b0;
    waddr = cnt_r[AW-1:0];
    wdata = in_tdata;
    if (rst_n && (state_r == S_IDLE) && in_tvalid && in_tready && (in_tuser == OP_PUSH) &&
        (cnt_r < CW'(STACK_DEPTH))) begin
      we = 1'b1;
    end else if (rst_n && (state_r == S_OUT) &&
                 (op_r == OP_ADD || op_r == OP_SUB || rsp.done)) begin
      we = 1'b1;
      waddr = cnt_r[AW-1:0] - AW'(2);
      wdata = rsp.done ? rsp.res : res_r;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      ovalid_r <= 1'b0;
    end else begin
      if (ovalid_r && out_tready) ovalid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_tvalid && in_tready) begin
            op_r <= in_tuser;
            if (in_tuser == OP_PUSH) begin
              if (cnt_r >= CW'(STACK_DEPTH)) begin
                st_r <= ST_FULL;
                state_r <= S_TOP;
              end else begin
                st_r <= ST_OK;
                cnt_r <= cnt_r + CW'(1);
                state_r <= S_WAIT;
              end
            end else if (in_tuser > OP_DIV) begin
              st_r <= ST_OK;
              state_r <= S_TOP;
            end else if (cnt_r < CW'(2)) begin
              st_r <= ST_FEW;
              state_r <= S_TOP;
            end else begin
              st_r <= ST_OK;
              state_r <= S_RD2;
            end
          end
        end
        S_RD2: begin
          second_r <= rdata_r;
          state_r <= S_RD1;
        end
        S_RD1: begin
          first_r <= rdata_r;
          state_r <= S_EXEC;
        end
        S_EXEC: begin
          if (op_r == OP_ADD) begin
            if (first_r[63] == second_r[63] && sum[63] != first_r[63]) begin
              res_r <= first_r[63] ? MIN_NEG : MAX_POS;
              st_r <= ST_SAT;
            end else begin
              res_r <= sum;
            end
          end else if (op_r == OP_SUB) begin
            if (first_r[63] != second_r[63] && dif[63] != first_r[63]) begin
              res_r <= first_r[63] ? MIN_NEG : MAX_POS;
              st_r <= ST_SAT;
            end else begin
              res_r <= dif;
            end
          end
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (op_r == OP_ADD || op_r == OP_SUB || rsp.done) begin
            if (rsp.done) begin
              st_r <= rsp.st;
            end
            state_r <= S_WAIT;
            cnt_r <= cnt_r - CW'(1);
          end
        end
        S_WAIT: state_r <= S_TOP;
        S_TOP: begin
          if (!ovalid_r) begin
            out_r <= {st_r, 5'(cnt_r), (cnt_r == '0) ? 64'd0 : rdata_r};
            ovalid_r <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `RPN_ASSERT_IMPL(a_depth, clk, rst_n, 1'b1, cnt_r <= CW'(STACK_DEPTH))
  `RPN_ASSERT_NEXT(a_hold, clk, rst_n, ovalid_r && !out_tready, ovalid_r && $stable(out_r))
  `RPN_ASSERT_IMPL(a_noacc, clk, rst_n, state_r != S_IDLE, !in_tready)
endmodule
